FILE: rtl/bma_pkg.sv
// Shared constants, codes and controller/datapath interface types for the buddy allocator.
// No dependencies; every other file refers to it by scoped names.
package bma_pkg;

  localparam int TOTAL_SIZE     = 1024;
  localparam int MIN_BLOCK_SIZE = 1;
  localparam int OWNER_BITS     = 8;
  localparam int LEVELS         = $clog2(TOTAL_SIZE);
  localparam int NODE_COUNT     = 2 * TOTAL_SIZE;
  localparam int NODE_W         = $clog2(NODE_COUNT);
  localparam int DEPTH_W        = 4;
  localparam int REQ_W          = 11;
  localparam int START_W        = 10;
  localparam int BSIZE_W        = 11;
  localparam int STATUS_W       = 2;

  localparam logic [STATUS_W-1:0] ST_ALLOC    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  localparam logic [2:0] AS_NODE  = 3'd0;
  localparam logic [2:0] AS_LEFT  = 3'd1;
  localparam logic [2:0] AS_RIGHT = 3'd2;
  localparam logic [2:0] AS_MSIB  = 3'd3;
  localparam logic [2:0] AS_MPAR  = 3'd4;
  localparam logic [2:0] AS_CLR   = 3'd5;

  localparam logic [1:0] MV_HOLD = 2'd0;
  localparam logic [1:0] MV_LEFT = 2'd1;
  localparam logic [1:0] MV_NEXT = 2'd2;
  localparam logic [1:0] MV_UP   = 2'd3;

  typedef struct packed {
    logic                load;
    logic [2:0]          addr_sel;
    logic                wr_en;
    logic                wr_split;
    logic                wr_alloc;
    logic                wr_owner;
    logic [1:0]          move;
    logic                mload;
    logic                mup;
    logic                set_found;
    logic                clr_inc;
    logic                res_set;
    logic [STATUS_W-1:0] res_status;
    logic                out_load;
  } bma_cmd_t;

  typedef struct packed {
    logic is_free_cmd;
    logic too_big;
    logic split;
    logic alloc;
    logic owner_eq;
    logic deeper;
    logic at_need;
    logic at_bottom;
    logic is_root;
    logic is_left;
    logic m_root;
    logic found;
    logic clr_done;
    logic out_free;
  } bma_stat_t;

  // Ceiling log2 of the request, with zero and small sizes raised to the minimum block.
  function automatic logic [DEPTH_W-1:0] need_log2(input logic [REQ_W-1:0] req);
    logic [REQ_W-1:0] n;
    logic [DEPTH_W-1:0] k;
    n = (req < REQ_W'(MIN_BLOCK_SIZE)) ? REQ_W'(MIN_BLOCK_SIZE) : req;
    k = DEPTH_W'(REQ_W);
    for (int i = REQ_W; i >= 0; i--) begin
      if ({1'b0, n} <= ((REQ_W + 1)'(1) << i)) k = DEPTH_W'(i);
    end
    return k;
  endfunction

endpackage

FILE: rtl/bma_ctrl.sv
// Controller state machine of the buddy allocator: walks the node tree one step at a time.
// Depends on bma_pkg; drives bma_dp through a command struct and reads its status struct.
module bma_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bma_pkg::bma_stat_t stat,
  output bma_pkg::bma_cmd_t  cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_EV  = 4'd3;
  localparam logic [3:0] S_A_SPL = 4'd4;
  localparam logic [3:0] S_A_SPR = 4'd5;
  localparam logic [3:0] S_A_RET = 4'd6;
  localparam logic [3:0] S_F_RD  = 4'd7;
  localparam logic [3:0] S_F_EV  = 4'd8;
  localparam logic [3:0] S_F_RET = 4'd9;
  localparam logic [3:0] S_M_RD  = 4'd10;
  localparam logic [3:0] S_M_EV  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.addr_sel = bma_pkg::AS_NODE;
    cmd.move = bma_pkg::MV_HOLD;
    cmd.res_status = bma_pkg::ST_NOFIT;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.addr_sel = bma_pkg::AS_CLR;
        cmd.wr_en = 1'b1;
        cmd.clr_inc = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_A_RD;
        end
      end
      S_A_RD: begin
        if (stat.is_free_cmd) begin
          state_next = S_F_EV;
        end else if (stat.too_big) begin
          cmd.res_set = 1'b1;
          cmd.res_status = bma_pkg::ST_NOFIT;
          state_next = S_DONE;
        end else begin
          state_next = S_A_EV;
        end
      end
      S_A_EV: begin
        if (stat.alloc || stat.deeper) begin
          state_next = S_A_RET;
        end else if (!stat.split && stat.at_need) begin
          cmd.wr_en = 1'b1;
          cmd.wr_alloc = 1'b1;
          cmd.wr_owner = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_status = bma_pkg::ST_ALLOC;
          state_next = S_DONE;
        end else if (stat.at_bottom) begin
          state_next = S_A_RET;
        end else if (!stat.split) begin
          cmd.wr_en = 1'b1;
          cmd.wr_split = 1'b1;
          state_next = S_A_SPL;
        end else begin
          cmd.move = bma_pkg::MV_LEFT;
          state_next = S_A_RD;
        end
      end
      S_A_SPL: begin
        cmd.addr_sel = bma_pkg::AS_LEFT;
        cmd.wr_en = 1'b1;
        state_next = S_A_SPR;
      end
      S_A_SPR: begin
        cmd.addr_sel = bma_pkg::AS_RIGHT;
        cmd.wr_en = 1'b1;
        cmd.move = bma_pkg::MV_LEFT;
        state_next = S_A_RD;
      end
      S_A_RET: begin
        if (stat.is_root) begin
          cmd.res_set = 1'b1;
          cmd.res_status = bma_pkg::ST_NOFIT;
          state_next = S_DONE;
        end else if (stat.is_left) begin
          cmd.move = bma_pkg::MV_NEXT;
          state_next = S_A_RD;
        end else begin
          cmd.move = bma_pkg::MV_UP;
        end
      end
      S_F_RD: begin
        state_next = S_F_EV;
      end
      S_F_EV: begin
        if (stat.split) begin
          cmd.move = bma_pkg::MV_LEFT;
          state_next = S_F_RD;
        end else if (stat.alloc && stat.owner_eq) begin
          cmd.wr_en = 1'b1;
          cmd.mload = 1'b1;
          cmd.set_found = 1'b1;
          state_next = S_M_RD;
        end else begin
          state_next = S_F_RET;
        end
      end
      S_F_RET: begin
        if (stat.is_root) begin
          cmd.res_set = 1'b1;
          cmd.res_status = stat.found ? bma_pkg::ST_FREED : bma_pkg::ST_NOTFOUND;
          state_next = S_DONE;
        end else if (stat.is_left) begin
          cmd.move = bma_pkg::MV_NEXT;
          state_next = S_F_RD;
        end else begin
          cmd.move = bma_pkg::MV_UP;
        end
      end
      S_M_RD: begin
        cmd.addr_sel = bma_pkg::AS_MSIB;
        state_next = stat.m_root ? S_F_RET : S_M_EV;
      end
      S_M_EV: begin
        if (stat.split || stat.alloc) begin
          state_next = S_F_RET;
        end else begin
          cmd.addr_sel = bma_pkg::AS_MPAR;
          cmd.wr_en = 1'b1;
          cmd.mup = 1'b1;
          state_next = S_M_RD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/bma_dp.sv
// Datapath of the buddy allocator: node flag and owner memories, walk registers, result register.
// Depends on bma_pkg; controlled by bma_ctrl through the command struct.
module bma_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  bma_pkg::bma_cmd_t                   cmd,
  output bma_pkg::bma_stat_t                  stat,
  input  logic                                in_command,
  input  logic [bma_pkg::REQ_W-1:0]           in_request_size,
  input  logic [bma_pkg::OWNER_BITS-1:0]      in_owner_id,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bma_pkg::STATUS_W-1:0]        out_status,
  output logic [bma_pkg::START_W-1:0]         out_block_start,
  output logic [bma_pkg::BSIZE_W-1:0]         out_block_len
);

  logic [1:0]                         flag_mem [bma_pkg::NODE_COUNT];
  logic [bma_pkg::OWNER_BITS-1:0]     owner_mem [bma_pkg::NODE_COUNT];
  logic [1:0]                         flag_q;
  logic [bma_pkg::OWNER_BITS-1:0]     owner_q;

  logic                               cmd_free;
  logic [bma_pkg::DEPTH_W-1:0]        need_k;
  logic [bma_pkg::OWNER_BITS-1:0]     owner;
  logic [bma_pkg::NODE_W-1:0]         node;
  logic [bma_pkg::DEPTH_W-1:0]        depth;
  logic [bma_pkg::NODE_W-1:0]         mcur;
  logic                               found;
  logic [bma_pkg::NODE_W-1:0]         clr_cnt;
  logic [bma_pkg::STATUS_W-1:0]       res_status;

  logic [bma_pkg::NODE_W-1:0]         addr;
  logic [bma_pkg::DEPTH_W-1:0]        need_depth;
  logic [bma_pkg::DEPTH_W-1:0]        shamt;
  logic [bma_pkg::NODE_W-1:0]         node_mask;
  logic [bma_pkg::NODE_W-1:0]         start_full;

  always_comb begin
    case (cmd.addr_sel)
      bma_pkg::AS_NODE:  addr = node;
      bma_pkg::AS_LEFT:  addr = {node[bma_pkg::NODE_W-2:0], 1'b0};
      bma_pkg::AS_RIGHT: addr = {node[bma_pkg::NODE_W-2:0], 1'b1};
      bma_pkg::AS_MSIB:  addr = mcur ^ bma_pkg::NODE_W'(1);
      bma_pkg::AS_MPAR:  addr = mcur >> 1;
      bma_pkg::AS_CLR:   addr = clr_cnt;
      default:           addr = node;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) flag_mem[addr] <= {cmd.wr_split, cmd.wr_alloc};
    if (cmd.wr_owner) owner_mem[addr] <= owner;
    flag_q <= flag_mem[addr];
    owner_q <= owner_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_inc) begin
      clr_cnt <= clr_cnt + bma_pkg::NODE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_free <= in_command;
      need_k <= bma_pkg::need_log2(in_request_size);
      owner <= in_owner_id;
      node <= bma_pkg::NODE_W'(1);
      depth <= '0;
      found <= 1'b0;
    end else begin
      case (cmd.move)
        bma_pkg::MV_LEFT: begin
          node <= {node[bma_pkg::NODE_W-2:0], 1'b0};
          depth <= depth + bma_pkg::DEPTH_W'(1);
        end
        bma_pkg::MV_NEXT: node <= node + bma_pkg::NODE_W'(1);
        bma_pkg::MV_UP: begin
          node <= node >> 1;
          depth <= depth - bma_pkg::DEPTH_W'(1);
        end
        default: ;
      endcase
      if (cmd.set_found) found <= 1'b1;
    end
    if (cmd.mload) begin
      mcur <= node;
    end else if (cmd.mup) begin
      mcur <= mcur >> 1;
    end
    if (cmd.res_set) res_status <= cmd.res_status;
  end

  assign need_depth = bma_pkg::DEPTH_W'(bma_pkg::LEVELS) - need_k;
  assign shamt = bma_pkg::DEPTH_W'(bma_pkg::LEVELS) - depth;
  assign node_mask = (bma_pkg::NODE_W'(1) << depth) - bma_pkg::NODE_W'(1);
  assign start_full = (node & node_mask) << shamt;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      if (res_status == bma_pkg::ST_ALLOC) begin
        out_block_start <= start_full[bma_pkg::START_W-1:0];
        out_block_len <= bma_pkg::BSIZE_W'(1) << shamt;
      end else begin
        out_block_start <= '0;
        out_block_len <= '0;
      end
    end
  end

  always_comb begin
    stat.is_free_cmd = cmd_free;
    stat.too_big = need_k > bma_pkg::DEPTH_W'(bma_pkg::LEVELS);
    stat.split = flag_q[1];
    stat.alloc = flag_q[0];
    stat.owner_eq = (owner_q == owner);
    stat.deeper = depth > need_depth;
    stat.at_need = depth == need_depth;
    stat.at_bottom = depth == bma_pkg::DEPTH_W'(bma_pkg::LEVELS);
    stat.is_root = node == bma_pkg::NODE_W'(1);
    stat.is_left = !node[0];
    stat.m_root = mcur == bma_pkg::NODE_W'(1);
    stat.found = found;
    stat.clr_done = &clr_cnt;
    stat.out_free = !out_valid || out_ready;
  end

endmodule

FILE: rtl/buddy_memory_allocator_core.sv
// Top level of the binary buddy allocator: stream ports, controller and datapath.
// Depends on bma_pkg, bma_ctrl and bma_dp.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: command; tdata: request_size, owner_id
//   m_axis    out        tuser: status; tdata: block_start, block length
//
// An allocate reads and evaluates each node visited, writes both children per split and
// steps up when backtracking; a free reads and evaluates each node visited, reads the
// sibling and writes the parent per merge level, and steps up when backtracking. The
// single-port node memory serialises all this. Node flags are cleared after reset before
// any transaction; a finished result waits in the output register while the next is taken.
module buddy_memory_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // request_size [10:0], owner_id [18:11], zero fill
  input  logic [0:0]  s_axis_tuser,   // command [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // block_start [9:0], block length [20:10], zero fill
  output logic [1:0]  m_axis_tuser    // status [1:0]
);

  bma_pkg::bma_cmd_t  cmd;
  bma_pkg::bma_stat_t stat;
  logic [bma_pkg::START_W-1:0] block_start;
  logic [bma_pkg::BSIZE_W-1:0] blk_len;

  bma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bma_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (s_axis_tuser[0]),
    .in_request_size (s_axis_tdata[10:0]),
    .in_owner_id     (s_axis_tdata[18:11]),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_status      (m_axis_tuser),
    .out_block_start (block_start),
    .out_block_len   (blk_len)
  );

  assign m_axis_tdata = {3'b000, blk_len, block_start};

endmodule
